[rtl/core/nfce_pkg.sv]
// Shared constants, command codes and types for the NOR flash command engine.
// No dependencies; nfce_cmd, nfce_sweep and the top module import this package.
`default_nettype none

package nfce_pkg;

    localparam int ADDR_W       = 14;
    localparam int DATA_W       = 16;
    localparam int ARRAY_WORDS  = 16384;
    localparam int SECTOR_WORDS = 256;
    localparam int SECTOR_COUNT = 64;
    localparam int SECTOR_BITS  = $clog2(SECTOR_WORDS);
    localparam int SEC_IDX_W    = ADDR_W - SECTOR_BITS;

    localparam logic [7:0] OP_READ_ARRAY    = 8'hFF;
    localparam logic [7:0] OP_STATUS        = 8'h70;
    localparam logic [7:0] OP_PROGRAM       = 8'h40;
    localparam logic [7:0] OP_ERASE_SETUP   = 8'h20;
    localparam logic [7:0] OP_ERASE_CONFIRM = 8'hD0;

    localparam logic [DATA_W-1:0] STATUS_READY = 16'h0080;
    localparam logic [DATA_W-1:0] ERASED_WORD  = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_ARRAY   = 2'd0,
        MODE_STATUS  = 2'd1,
        MODE_PROGRAM = 2'd2,
        MODE_ERASE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic                 go;
        logic [SEC_IDX_W-1:0] sector;
    } erase_req_t;

    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] addr;
    } sweep_t;

endpackage

`default_nettype wire

[rtl/core/nfce_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module nfce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/nfce_cmd.sv]
// Command decoder: holds the command mode and raises erase requests.
// Depends on nfce_pkg.
`default_nettype none

module nfce_cmd (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          action,
    input  wire logic [nfce_pkg::ADDR_W-1:0]   word_address,
    input  wire logic [nfce_pkg::DATA_W-1:0]   write_data,
    output nfce_pkg::mode_t                    mode,
    output nfce_pkg::erase_req_t               erase_req
);

    import nfce_pkg::*;

    mode_t                mode_reg;
    mode_t                mode_next;
    logic [7:0]           op;
    logic [SEC_IDX_W-1:0] sector;
    logic                 sector_ok;

    assign op        = write_data[7:0];
    assign sector    = word_address[ADDR_W-1:SECTOR_BITS];
    assign sector_ok = 32'(sector) < 32'(SECTOR_COUNT);

    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_PROGRAM: mode_next = MODE_STATUS;
            MODE_ERASE:   mode_next = (op == OP_ERASE_CONFIRM) ? MODE_STATUS : MODE_ARRAY;
            default:
            begin
                case (op)
                    OP_READ_ARRAY:  mode_next = MODE_ARRAY;
                    OP_STATUS:      mode_next = MODE_STATUS;
                    OP_PROGRAM:     mode_next = MODE_PROGRAM;
                    OP_ERASE_SETUP: mode_next = MODE_ERASE;
                    default:        mode_next = mode_reg;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ARRAY;
        end
        else if (accept && action)
        begin
            mode_reg <= mode_next;
        end
    end

    assign mode             = mode_reg;
    assign erase_req.go     = accept && action && (mode_reg == MODE_ERASE)
                              && (op == OP_ERASE_CONFIRM) && sector_ok;
    assign erase_req.sector = sector;

endmodule

`default_nettype wire

[rtl/core/nfce_sweep.sv]
// Erase sweeper: walks the cell memory one word a cycle writing erased words,
// over the whole array after reset and over one sector per erase. Uses nfce_pkg.
`default_nettype none

module nfce_sweep (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire nfce_pkg::erase_req_t  erase_req,
    output nfce_pkg::sweep_t           sweep
);

    import nfce_pkg::*;

    logic              active_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            addr_reg   <= '0;
            last_reg   <= '1;
        end
        else if (erase_req.go)
        begin
            active_reg <= 1'b1;
            addr_reg   <= {erase_req.sector, {SECTOR_BITS{1'b0}}};
            last_reg   <= {erase_req.sector, {SECTOR_BITS{1'b1}}};
        end
        else if (active_reg)
        begin
            // drop out after the last word of the range is written
            if (addr_reg == last_reg)
            begin
                active_reg <= 1'b0;
            end
            addr_reg <= addr_reg + ADDR_W'(1);
        end
    end

    assign sweep.active = active_reg;
    assign sweep.addr   = addr_reg;

endmodule

`default_nettype wire

[rtl/core/nor_flash_command_engine_top.sv]
// NOR flash command engine: 16-bit word array in one synchronous RAM.
// done follows the accepting edge through s1_valid_reg and then done_reg. Reads and
// commands leave busy low; a program holds busy for its read-modify-write on
// the cell RAM; an erase holds busy while its sector is swept.
// Reset: mode is read array; busy stays high while the whole RAM is swept
// to erased words. The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none

module nor_flash_command_engine_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         action,
    input  wire logic [nfce_pkg::ADDR_W-1:0]  word_address,
    input  wire logic [nfce_pkg::DATA_W-1:0]  write_data,
    output logic                              done,
    output logic      [nfce_pkg::DATA_W-1:0]  read_data
);

    import nfce_pkg::*;

    logic              accept;
    mode_t             mode;
    erase_req_t        erase_req;
    sweep_t            sweep;

    logic              s1_valid_reg;
    logic              s1_action_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_data_reg;
    mode_t             s1_mode_reg;

    logic              prog_we;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    logic              done_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;

    // interlock: a program in its write-back cycle blocks the next transfer
    assign prog_we = s1_valid_reg && s1_action_reg && (s1_mode_reg == MODE_PROGRAM);
    assign busy    = sweep.active || prog_we;
    assign accept  = start && !busy;

    nfce_cmd u_cmd (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .word_address (word_address),
        .write_data   (write_data),
        .mode         (mode),
        .erase_req    (erase_req)
    );

    nfce_sweep u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .erase_req (erase_req),
        .sweep     (sweep)
    );

    assign ram_we    = sweep.active || prog_we;
    assign ram_waddr = sweep.active ? sweep.addr : s1_addr_reg;
    assign ram_wdata = sweep.active ? ERASED_WORD : (ram_rdata & s1_data_reg);

    nfce_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ARRAY_WORDS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_address),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    // hold the item and the mode it was issued under while the RAM read lands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_addr_reg   <= word_address;
            s1_data_reg   <= write_data;
            s1_mode_reg   <= mode;
        end
        read_data_reg <= read_data_next;
    end

    always_comb
    begin
        if (s1_action_reg)
        begin
            read_data_next = '0;
        end
        else if (s1_mode_reg == MODE_ARRAY)
        begin
            read_data_next = ram_rdata;
        end
        else
        begin
            read_data_next = STATUS_READY;
        end
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("done did not follow a transfer by two cycles");

    a_done_has_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("done strobe without a transfer");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(sweep.active && prog_we))
        else $error("sweep and program write collide on the cell RAM");

    a_prog_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action && (mode == MODE_PROGRAM)) |=> busy)
        else $error("program write-back not interlocked");

endmodule

`default_nettype wire

[tb/sv/tb_nor_flash_command_engine_top.sv]
// Self-checking testbench for nor_flash_command_engine_top: bus reads and writes in,
// one read_data word back per access, checked against a mirror of the flash array.
// Depends on nfce_pkg and the nor_flash_command_engine_top RTL only.
`default_nettype none

module tb_nor_flash_command_engine_top;

    import nfce_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Codes outside the command set, for the ignore and abort paths
    localparam logic [7:0] OP_UNDEFINED   = 8'h33;
    localparam logic [7:0] OP_STRAY       = 8'h11;
    localparam logic [7:0] OP_BAD_CONFIRM = 8'hD1;

    localparam int RANDOM_ITEMS = 625;
    localparam int IDLE_LIMIT   = 4 * ARRAY_WORDS;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] word_address;
        logic [DATA_W-1:0] write_data;
    } flash_access_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              action       = 1'b0;
    logic [ADDR_W-1:0] word_address = '0;
    logic [DATA_W-1:0] write_data   = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] read_data;

    nor_flash_command_engine_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .word_address (word_address),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data)
    );

    always #10 clk = ~clk;

    flash_access_t     access_backlog[$];
    logic [DATA_W-1:0] expected_read_data[$];

    // Mirror of the flash contents and command mode
    logic [DATA_W-1:0] flash_image [ARRAY_WORDS];
    mode_t             flash_mode;

    int total_items;
    int accepted_count;
    int mismatch_count;
    int read_total;
    int program_total;
    int erase_total;
    int abort_total;

    function automatic logic [DATA_W-1:0] flash_respond(flash_access_t a);
        logic [DATA_W-1:0] reply;
        int                sector;
        int                w;
        reply = '0;
        if (a.action == ACT_READ) begin
            read_total++;
            reply = (flash_mode == MODE_ARRAY) ? flash_image[a.word_address] : STATUS_READY;
        end else begin
            case (flash_mode)
                MODE_PROGRAM:
                begin
                    // NOR cells only clear bits
                    flash_image[a.word_address] = flash_image[a.word_address] & a.write_data;
                    flash_mode = MODE_STATUS;
                    program_total++;
                end
                MODE_ERASE:
                begin
                    if (a.write_data[7:0] == OP_ERASE_CONFIRM) begin
                        sector = int'(a.word_address) / SECTOR_WORDS;
                        if (sector < SECTOR_COUNT) begin
                            for (w = sector * SECTOR_WORDS;
                                 w < (sector + 1) * SECTOR_WORDS && w < ARRAY_WORDS; w++)
                                flash_image[w] = ERASED_WORD;
                        end
                        flash_mode = MODE_STATUS;
                        erase_total++;
                    end else begin
                        flash_mode = MODE_ARRAY;
                        abort_total++;
                    end
                end
                default:
                begin
                    case (a.write_data[7:0])
                        OP_READ_ARRAY:  flash_mode = MODE_ARRAY;
                        OP_STATUS:      flash_mode = MODE_STATUS;
                        OP_PROGRAM:     flash_mode = MODE_PROGRAM;
                        OP_ERASE_SETUP: flash_mode = MODE_ERASE;
                        default:        ;
                    endcase
                end
            endcase
        end
        return reply;
    endfunction

    task automatic push_access(input logic act, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        flash_access_t a;
        a.action       = act;
        a.word_address = addr;
        a.write_data   = data;
        access_backlog.push_back(a);
        total_items++;
    endtask

    // Command byte with random junk in the ignored upper byte
    function automatic logic [DATA_W-1:0] with_junk(input logic [7:0] op);
        logic [15:0] r;
        r = 16'($urandom);
        return {r[15:8], op};
    endfunction

    // Mostly a few hot sectors so reads find programmed words, sometimes anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        logic [5:0]        sec;
        a = ADDR_W'($urandom);
        if ($urandom_range(0, 99) < 65) begin
            case ($urandom_range(0, 3))
                0:       sec = 6'd0;
                1:       sec = 6'd1;
                2:       sec = 6'd63;
                default: sec = 6'($urandom);
            endcase
            a = {sec, 8'($urandom_range(0, 15))};
        end
        return a;
    endfunction

    // Driver: bursts of back-to-back transfers separated by random gaps
    flash_access_t held_access;
    int            burst_left = 0;
    int            gap_left   = 0;

    always @(posedge clk) begin
        logic fire;
        logic next_start;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            fire = start && !busy;
            if (fire) begin
                expected_read_data.push_back(flash_respond(held_access));
                accepted_count++;
            end
            if (!start || fire) begin
                next_start = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (access_backlog.size() > 0) begin
                    held_access  = access_backlog.pop_front();
                    action       <= held_access.action;
                    word_address <= held_access.word_address;
                    write_data   <= held_access.write_data;
                    next_start   = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            9:          gap_left = $urandom_range(20, 60);
                            default:    gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
                start <= next_start;
            end
        end
    end

    // Monitor: every strobe must match the oldest prediction
    always @(posedge clk) begin
        logic [DATA_W-1:0] want;
        if (rst_n && done) begin
            if (expected_read_data.size() == 0) begin
                $error("read_data: no transfer outstanding, actual %h", read_data);
                mismatch_count++;
            end else begin
                want = expected_read_data.pop_front();
                if (read_data !== want) begin
                    $error("read_data: expected %h actual %h", want, read_data);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run once nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("nor_flash_command_engine_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int               directed_items;
        int               kind;
        int               n;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;

        for (int i = 0; i < ARRAY_WORDS; i++)
            flash_image[i] = ERASED_WORD;
        flash_mode = MODE_ARRAY;

        // Directed: array ends, program and read-back, unknown commands,
        // reads while armed, last-sector erase, aborted erase
        push_access(ACT_READ,  14'h0000, 16'h0000);
        push_access(ACT_READ,  14'h3FFF, 16'hFFFF);
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_PROGRAM});
        push_access(ACT_READ,  14'h1234, 16'h0000);
        push_access(ACT_WRITE, 14'h0000, 16'h0000);
        push_access(ACT_READ,  14'h0000, 16'h0000);
        push_access(ACT_WRITE, 14'h3FFF, {8'hAB, OP_PROGRAM});
        push_access(ACT_WRITE, 14'h3FFF, 16'h5A5A);
        push_access(ACT_WRITE, 14'h0000, {8'h12, OP_READ_ARRAY});
        push_access(ACT_READ,  14'h0000, 16'h0000);
        push_access(ACT_READ,  14'h3FFF, 16'h0000);
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_UNDEFINED});
        push_access(ACT_READ,  14'h3FFF, 16'h0000);
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_STATUS});
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_STRAY});
        push_access(ACT_READ,  14'h3FFF, 16'h0000);
        push_access(ACT_WRITE, 14'h0000, {8'hFF, OP_ERASE_SETUP});
        push_access(ACT_READ,  14'h0000, 16'h0000);
        push_access(ACT_WRITE, 14'h3F05, {8'hFF, OP_ERASE_CONFIRM});
        push_access(ACT_READ,  14'h3FFF, 16'h0000);
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_READ_ARRAY});
        push_access(ACT_READ,  14'h3FFF, 16'h0000);
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_ERASE_SETUP});
        push_access(ACT_WRITE, 14'h0000, {8'h00, OP_BAD_CONFIRM});
        push_access(ACT_READ,  14'h0000, 16'h0000);
        directed_items = total_items;

        // Random: mostly well-formed command sequences, the rest noise
        while (total_items - directed_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            addr = pick_address();
            if (kind < 30) begin
                data = ($urandom_range(0, 1) != 0) ? 16'($urandom | $urandom) : 16'($urandom);
                push_access(ACT_WRITE, pick_address(), with_junk(OP_PROGRAM));
                push_access(ACT_WRITE, addr, data);
                if ($urandom_range(0, 1) != 0)
                    push_access(ACT_READ, pick_address(), 16'($urandom));
                push_access(ACT_WRITE, pick_address(), with_junk(OP_READ_ARRAY));
                push_access(ACT_READ, addr, 16'($urandom));
            end else if (kind < 38) begin
                push_access(ACT_WRITE, pick_address(), with_junk(OP_ERASE_SETUP));
                push_access(ACT_WRITE, addr, with_junk(OP_ERASE_CONFIRM));
                push_access(ACT_READ, pick_address(), 16'($urandom));
                push_access(ACT_WRITE, pick_address(), with_junk(OP_READ_ARRAY));
                push_access(ACT_READ, {addr[13:8], 8'($urandom_range(0, 15))}, 16'($urandom));
            end else if (kind < 46) begin
                data = 16'($urandom);
                if (data[7:0] == OP_ERASE_CONFIRM)
                    data[0] = ~data[0];
                push_access(ACT_WRITE, pick_address(), with_junk(OP_ERASE_SETUP));
                push_access(ACT_WRITE, addr, data);
                push_access(ACT_READ, addr, 16'($urandom));
            end else if (kind < 56) begin
                push_access(ACT_WRITE, pick_address(), with_junk(OP_STATUS));
                n = $urandom_range(1, 3);
                repeat (n) push_access(ACT_READ, pick_address(), 16'($urandom));
            end else if (kind < 76) begin
                push_access(ACT_WRITE, pick_address(), with_junk(OP_READ_ARRAY));
                n = $urandom_range(1, 4);
                repeat (n) push_access(ACT_READ, pick_address(), 16'($urandom));
            end else begin
                data = 16'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 4))
                        0:       data = with_junk(OP_READ_ARRAY);
                        1:       data = with_junk(OP_STATUS);
                        2:       data = with_junk(OP_PROGRAM);
                        3:       data = with_junk(OP_ERASE_SETUP);
                        default: data = with_junk(OP_ERASE_CONFIRM);
                    endcase
                end
                push_access(logic'($urandom_range(0, 1)), addr, data);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items || expected_read_data.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_read_data.size() != 0)
            $error("read_data: %0d transfers never answered", expected_read_data.size());

        $display("covered %0d accesses (%0d directed): %0d reads, %0d programs,",
                 accepted_count, directed_items, read_total, program_total);
        $display("%0d sector erases and %0d aborted erases", erase_total, abort_total);
        if (mismatch_count == 0 && expected_read_data.size() == 0) begin
            $display("nor_flash_command_engine_top verification clean");
        end else begin
            $display("nor_flash_command_engine_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
